// ===== rtl/grhf_pkg.sv =====
// grhf_pkg: shared types and constants for the gray rotate hole fill block
// no dependencies
package grhf_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_word;

    typedef struct packed {
        logic [7:0] gray;
        logic [8:0] col;
        logic [8:0] row;
        logic       last_pixel;
    } t_out_word;

    // queue entry between front and back
    typedef struct packed {
        logic        is_emit;
        logic        wr_ok;
        logic [7:0]  luma;
        logic [11:0] tx;
        logic [11:0] ty;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD_CTR, ST_RD_UP, ST_RD_LT, ST_RD_RT, ST_RD_DN, ST_DONE
    } t_bstate;

    localparam logic [2:0] REG_COS = 3'd0;
    localparam logic [2:0] REG_SIN = 3'd1;
    localparam logic [2:0] REG_CX  = 3'd2;
    localparam logic [2:0] REG_CY  = 3'd3;
    localparam logic [2:0] REG_W   = 3'd4;
    localparam logic [2:0] REG_H   = 3'd5;

endpackage

// ===== rtl/grhf_front.sv =====
// grhf_front: accepts words, computes luma and rotated target for loads
// depends on grhf_pkg
module grhf_front #(
    parameter int CW = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  grhf_pkg::t_in_word    i_word,
    input  logic [15:0]           i_cos,
    input  logic [15:0]           i_sin,
    input  logic [8:0]            i_cx,
    input  logic [8:0]            i_cy,
    input  logic [CW-1:0]         i_w,
    input  logic [CW-1:0]         i_h,
    output logic                  o_busy,
    output logic                  o_valid,
    output grhf_pkg::t_cmd        o_cmd,
    input  logic                  i_pop
);
    import grhf_pkg::*;

    // stage 1: products; stage 2: sums and truncation
    logic              r_s1_v, r_s2_v, r_emit1;
    logic [7:0]        r_luma1;
    logic signed [35:0] r_p_xc, r_p_ys, r_p_xs, r_p_yc;
    logic [8:0]        r_cx1, r_cy1;
    logic [CW-1:0]     r_lc, r_lr, n_lc, n_lr, lc_fix, lr_fix;
    t_cmd              r_cmd;
    logic [25:0]       lsum;
    logic signed [CW+1:0] dx, dy;
    logic signed [47:0] sx, sy, qx, qy;

    assign o_busy  = r_s1_v || r_s2_v;
    assign o_valid = r_s2_v;
    assign o_cmd   = r_cmd;

    always_comb begin
        lsum = 26'(19595 * i_word.red) + 26'(38470 * i_word.green)
             + 26'(7471 * i_word.blue);
        if (r_lc >= i_w || r_lr >= i_h) begin
            lc_fix = '0;
            lr_fix = '0;
        end else begin
            lc_fix = r_lc;
            lr_fix = r_lr;
        end
        n_lc = lc_fix + 1'b1;
        n_lr = lr_fix;
        if (n_lc >= i_w) begin
            n_lc = '0;
            n_lr = lr_fix + 1'b1;
            if (n_lr >= i_h) n_lr = '0;
        end
        dx = $signed({2'b0, lc_fix}) - $signed({{(CW-7){1'b0}}, i_cx});
        dy = $signed({2'b0, lr_fix}) - $signed({{(CW-7){1'b0}}, i_cy});
        sx = 48'(r_p_xc) - 48'(r_p_ys) + $signed({27'd0, r_cx1, 12'd0} <<< 2);
        sy = 48'(r_p_xs) + 48'(r_p_yc) + $signed({27'd0, r_cy1, 12'd0} <<< 2);
        // truncate toward zero
        qx = (sx < 0) ? -((-sx) >>> 14) : (sx >>> 14);
        qy = (sy < 0) ? -((-sy) >>> 14) : (sy >>> 14);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_lc   <= '0;
            r_lr   <= '0;
        end else begin
            if (i_take) begin
                r_s1_v <= 1'b1;
                r_emit1 <= i_word.operation;
                r_luma1 <= lsum[23:16];
                r_p_xc <= 36'(dx) * 36'($signed(i_cos));
                r_p_ys <= 36'(dy) * 36'($signed(i_sin));
                r_p_xs <= 36'(dx) * 36'($signed(i_sin));
                r_p_yc <= 36'(dy) * 36'($signed(i_cos));
                r_cx1  <= i_cx;
                r_cy1  <= i_cy;
                if (!i_word.operation) begin
                    r_lc <= n_lc;
                    r_lr <= n_lr;
                end
            end else if (r_s1_v && !r_s2_v) begin
                r_s1_v <= 1'b0;
                r_s2_v <= 1'b1;
                r_cmd.is_emit <= r_emit1;
                r_cmd.luma <= r_luma1;
                r_cmd.wr_ok <= qx >= 0 && qx < 48'(i_w) && qy >= 0 && qy < 48'(i_h);
                r_cmd.tx <= qx[11:0];
                r_cmd.ty <= qy[11:0];
            end
            if (i_pop) r_s2_v <= 1'b0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_take |-> !o_busy)
        else $error("take while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid)
        else $error("pop while empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(r_s1_v && r_s2_v))
        else $error("two words in flight");
endmodule

// ===== rtl/grhf_back.sv =====
// grhf_back: frame memory, clearing pass, load writes and emit with hole fill
// depends on grhf_pkg
module grhf_back #(
    parameter int CW = 12,
    parameter int MW = 512,
    parameter int MH = 512,
    parameter int AW = 18
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  grhf_pkg::t_cmd        i_cmd,
    input  logic [CW-1:0]         i_w,
    input  logic [CW-1:0]         i_h,
    output logic                  o_pop,
    output logic                  o_clearing,
    output logic                  o_busy,
    output logic                  o_strobe,
    output grhf_pkg::t_out_word   o_word
);
    import grhf_pkg::*;

    logic [7:0]   mem [MW*MH];
    logic [7:0]   r_rd;
    logic [AW-1:0] r_clr, rd_addr, r_at;
    logic          r_clearing;
    t_bstate       r_st, n_st;
    logic [CW-1:0] r_ec, r_er, ec_fix, er_fix, n_ec, n_er;
    logic [9:0]    r_sum;
    logic [7:0]    r_ctr;
    logic          interior, wr_en, rd_phase;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          r_strobe;
    t_out_word     r_out;

    assign o_clearing = r_clearing;
    assign o_strobe = r_strobe;
    assign o_word = r_out;
    assign o_busy = r_st != ST_IDLE;
    assign o_pop = i_valid && !r_clearing && r_st == ST_IDLE;

    always_comb begin
        if (r_ec >= i_w || r_er >= i_h) begin
            ec_fix = '0;
            er_fix = '0;
        end else begin
            ec_fix = r_ec;
            er_fix = r_er;
        end
        n_ec = ec_fix + 1'b1;
        n_er = er_fix;
        if (n_ec >= i_w) begin
            n_ec = '0;
            n_er = er_fix + 1'b1;
            if (n_er >= i_h) n_er = '0;
        end
        interior = ec_fix != 0 && er_fix != 0 && ec_fix + 1'b1 < i_w && er_fix + 1'b1 < i_h;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:   if (o_pop && i_cmd.is_emit) n_st = ST_RD_CTR;
            ST_RD_CTR: n_st = ST_RD_UP;
            ST_RD_UP:  n_st = (r_ctr == 8'd0 && interior) ? ST_RD_LT : ST_DONE;
            ST_RD_LT:  n_st = ST_RD_RT;
            ST_RD_RT:  n_st = ST_RD_DN;
            ST_RD_DN:  n_st = ST_DONE;
            ST_DONE:   n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    // read address and write port selection
    always_comb begin
        rd_addr = r_at;
        wr_en = 1'b0;
        wr_addr = r_at;
        wr_data = 8'(r_sum >> 2);
        unique case (r_st)
            ST_IDLE:   rd_addr = AW'(er_fix) * AW'(MW) + AW'(ec_fix);
            ST_RD_CTR: rd_addr = r_at - AW'(MW);
            ST_RD_UP:  rd_addr = r_at - 1'b1;
            ST_RD_LT:  rd_addr = r_at + 1'b1;
            ST_RD_RT:  rd_addr = r_at + AW'(MW);
            ST_RD_DN:  rd_addr = r_at;
            ST_DONE:   wr_en = r_ctr == 8'd0 && interior;
            default:   rd_addr = r_at;
        endcase
        if (r_clearing) begin
            wr_en = 1'b1;
            wr_addr = r_clr;
            wr_data = 8'd0;
        end else if (o_pop && !i_cmd.is_emit) begin
            wr_en = i_cmd.wr_ok;
            wr_addr = AW'(i_cmd.ty) * AW'(MW) + AW'(i_cmd.tx);
            wr_data = i_cmd.luma;
        end
        rd_phase = r_st != ST_DONE;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_phase) r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_clearing <= 1'b1;
            r_clr <= '0;
            r_ec <= '0;
            r_er <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_st <= n_st;
            r_strobe <= 1'b0;
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == AW'(MW*MH-1)) r_clearing <= 1'b0;
            end
            // counter is brought into the image only when an emit starts
            if (r_st == ST_IDLE && o_pop && i_cmd.is_emit) begin
                r_at <= rd_addr;
                r_ec <= ec_fix;
                r_er <= er_fix;
            end
            if (r_st == ST_DONE) begin
                r_strobe <= 1'b1;
                r_out.gray <= (r_ctr == 8'd0 && interior) ? 8'(r_sum >> 2) : r_ctr;
                r_out.col <= 9'(ec_fix);
                r_out.row <= 9'(er_fix);
                r_out.last_pixel <= ec_fix + 1'b1 == i_w && er_fix + 1'b1 == i_h;
                r_ec <= n_ec;
                r_er <= n_er;
            end
        end
    end

    // center arrives in rd_ctr, up in rd_up, then left, right, down
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_RD_CTR: begin
                r_ctr <= r_rd;
                r_sum <= '0;
            end
            ST_RD_UP: r_sum <= 10'(r_rd);
            ST_RD_LT, ST_RD_RT, ST_RD_DN: r_sum <= r_sum + 10'(r_rd);
            ST_DONE:  r_sum <= r_sum;
            default:  r_sum <= r_sum;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_clearing |-> !o_pop)
        else $error("pop during clear");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_st) == ST_DONE) else $error("stray strobe");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_DONE |=> r_st == ST_IDLE) else $error("done stuck");
endmodule

// ===== rtl/gray_rotate_hole_fill.sv =====
// gray_rotate_hole_fill: top level, apb registers, front and back parts
// depends on grhf_pkg, grhf_front, grhf_back
//
//  channel   handshake              payload
//  command   start / busy           i_cmd (operation, red, green, blue)
//  result    o_done strobe          o_result (gray, col, row, last_pixel)
//  config    apb psel/penable/...   pwdata, 6 registers at 4*i
//
// a load word passes a product stage and then a sum stage, then the back part
//   writes the frame memory as it pops the word; no new word is taken before the pop
// an emit word reads center and up, then left, right and down when the pixel is
//   an interior hole, whose mean is then written back; the result strobe is
//   registered in the final state
// after reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT words of the frame
//   memory while busy stays high; register writes are taken meanwhile
// the receiver cannot stall: each result is valid for one cycle on o_done
module gray_rotate_hole_fill #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  grhf_pkg::t_in_word   i_cmd,
    output logic                 o_done,
    output grhf_pkg::t_out_word  o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import grhf_pkg::*;
    // counters wide enough for max size plus headroom
    localparam int CW = 13;
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    logic [15:0] r_cos, r_sin;
    logic [8:0]  r_cx, r_cy;
    logic [9:0]  r_w, r_h;
    logic [CW-1:0] w_use, h_use;
    logic        take, f_busy, f_valid, pop, clearing, b_busy;
    t_cmd        cmd;

    assign pready = 1'b1;
    assign busy = f_busy || f_valid || clearing || b_busy;
    assign take = start && !busy;

    // clamp the sizes to [1, max]
    always_comb begin
        if (r_w == 10'd0) w_use = CW'(1);
        else if (CW'(r_w) > CW'(MAX_WIDTH)) w_use = CW'(MAX_WIDTH);
        else w_use = CW'(r_w);
        if (r_h == 10'd0) h_use = CW'(1);
        else if (CW'(r_h) > CW'(MAX_HEIGHT)) h_use = CW'(MAX_HEIGHT);
        else h_use = CW'(r_h);
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= 16'd16384;
            r_sin <= '0;
            r_cx  <= 9'd256;
            r_cy  <= 9'd256;
            r_w   <= 10'd512;
            r_h   <= 10'd512;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_COS: r_cos <= pwdata[15:0];
                REG_SIN: r_sin <= pwdata[15:0];
                REG_CX:  r_cx  <= pwdata[8:0];
                REG_CY:  r_cy  <= pwdata[8:0];
                REG_W:   r_w   <= pwdata[9:0];
                REG_H:   r_h   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_COS: prdata = {16'd0, r_cos};
            REG_SIN: prdata = {16'd0, r_sin};
            REG_CX:  prdata = {23'd0, r_cx};
            REG_CY:  prdata = {23'd0, r_cy};
            REG_W:   prdata = {22'd0, r_w};
            REG_H:   prdata = {22'd0, r_h};
            default: prdata = '0;
        endcase
    end

    grhf_front #(.CW(CW)) u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_word(i_cmd),
        .i_cos(r_cos), .i_sin(r_sin), .i_cx(r_cx), .i_cy(r_cy),
        .i_w(w_use), .i_h(h_use),
        .o_busy(f_busy), .o_valid(f_valid), .o_cmd(cmd), .i_pop(pop)
    );

    grhf_back #(.CW(CW), .MW(MAX_WIDTH), .MH(MAX_HEIGHT), .AW(AW)) u_back (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_cmd(cmd),
        .i_w(w_use), .i_h(h_use),
        .o_pop(pop), .o_clearing(clearing), .o_busy(b_busy),
        .o_strobe(o_done), .o_word(o_result)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n) take |=> busy)
        else $error("not busy after take");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) clearing |-> !take)
        else $error("take during clear");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> !$past(o_done))
        else $error("double result");
endmodule

// ===== verif/testbench.sv =====
// testbench for gray_rotate_hole_fill: rotates small images, reads them back
// depends on grhf_pkg and the gray_rotate_hole_fill rtl
`timescale 1ns / 1ps

module testbench;
    import grhf_pkg::*;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;
    localparam int   FRAME_W = 512;
    localparam int   FRAME_H = 512;
    // clearing pass after reset, several times over
    localparam int   STALL_LIMIT = 1200000;
    localparam int   DRAIN_CYCLES = 24;

    // frame predictor: owns its own copy of registers, counters and frame store
    class gray_frame_model;
        bit [7:0]  frame [FRAME_W * FRAME_H];
        bit [8:0]  ld_col, ld_row, em_col, em_row;
        bit [15:0] cos_r, sin_r;
        bit [8:0]  cx_r, cy_r;
        bit [9:0]  width_r, height_r;
        t_out_word expected_pixels[$];
        int        mismatches;
        int        pixels_seen;
        int        words_taken;

        function new();
            foreach (frame[i]) frame[i] = '0;
            cos_r = 16'd16384; sin_r = '0; cx_r = 9'd256; cy_r = 9'd256;
            width_r = 10'd512; height_r = 10'd512;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_COS: cos_r    = val[15:0];
                REG_SIN: sin_r    = val[15:0];
                REG_CX:  cx_r     = val[8:0];
                REG_CY:  cy_r     = val[8:0];
                REG_W:   width_r  = val[9:0];
                REG_H:   height_r = val[9:0];
                default: ;
            endcase
        endfunction

        function int clamp_size(bit [9:0] v, int top);
            if (v == 0) return 1;
            if (v > top) return top;
            return v;
        endfunction

        function void step_counter(ref bit [8:0] c, ref bit [8:0] r, input int wd, int ht);
            if (c + 1 >= wd) begin
                c = 0;
                r = (r + 1 >= ht) ? 9'd0 : r + 9'd1;
            end else begin
                c = c + 9'd1;
            end
        endfunction

        function void take_word(t_in_word w);
            int      wd, ht, at;
            int unsigned luma;
            longint  c, s, dx, dy, tx, ty;
            bit [8:0] col, row;
            int unsigned v, sum;
            t_out_word r;
            wd = clamp_size(width_r, FRAME_W);
            ht = clamp_size(height_r, FRAME_H);
            words_taken++;
            if (w.operation == OP_LOAD) begin
                if (ld_col >= wd || ld_row >= ht) begin
                    ld_col = 0; ld_row = 0;
                end
                luma = (19595 * w.red + 38470 * w.green + 7471 * w.blue) >> 16;
                c  = longint'($signed(cos_r));
                s  = longint'($signed(sin_r));
                dx = longint'(ld_col) - longint'(cx_r);
                dy = longint'(ld_row) - longint'(cy_r);
                // signed division truncates toward zero
                tx = (dx * c - dy * s + longint'(cx_r) * 16384) / 16384;
                ty = (dx * s + dy * c + longint'(cy_r) * 16384) / 16384;
                if (tx >= 0 && tx < wd && ty >= 0 && ty < ht)
                    frame[ty * FRAME_W + tx] = luma[7:0];
                step_counter(ld_col, ld_row, wd, ht);
            end else begin
                if (em_col >= wd || em_row >= ht) begin
                    em_col = 0; em_row = 0;
                end
                col = em_col;
                row = em_row;
                at  = row * FRAME_W + col;
                v   = frame[at];
                // interior hole: mean of four neighbours, up and left already repaired
                if (v == 0 && col > 0 && row > 0 && col + 1 < wd && row + 1 < ht) begin
                    sum = frame[at - FRAME_W] + frame[at - 1] + frame[at + 1]
                        + frame[at + FRAME_W];
                    v = sum >> 2;
                    frame[at] = v[7:0];
                end
                r.gray       = v[7:0];
                r.col        = col;
                r.row        = row;
                r.last_pixel = (col + 1 == wd && row + 1 == ht);
                expected_pixels.push_back(r);
                step_counter(em_col, em_row, wd, ht);
            end
        endfunction

        function void match_pixel(t_out_word got);
            t_out_word exp_w;
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                $error("pixel with no word pending: %p", got);
                mismatches++;
                return;
            end
            exp_w = expected_pixels.pop_front();
            if (got.gray != exp_w.gray) begin
                $error("gray expected %0d got %0d", exp_w.gray, got.gray);
                mismatches++;
            end
            if (got.col != exp_w.col) begin
                $error("col expected %0d got %0d", exp_w.col, got.col);
                mismatches++;
            end
            if (got.row != exp_w.row) begin
                $error("row expected %0d got %0d", exp_w.row, got.row);
                mismatches++;
            end
            if (got.last_pixel != exp_w.last_pixel) begin
                $error("last_pixel expected %0d got %0d", exp_w.last_pixel, got.last_pixel);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_word    i_cmd = '0;
    logic        o_done;
    t_out_word   o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gray_frame_model frame_model = new();
    int stall_cycles = 0;
    int phases_run = 0;

    gray_rotate_hole_fill u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd, .o_done, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: the block strobes each pixel for one cycle, no backpressure
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            frame_model.match_pixel(o_result);
    end

    // watchdog: count cycles where neither a word nor a pixel moves
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", stall_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // start stays high between back-to-back words; this task lowers it only for a gap
    task automatic send_word(t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy);
        frame_model.take_word(w);
    endtask

    // setup, access, then idle before the next transfer
    task automatic write_reg(logic [2:0] idx, int val);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frame_model.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // quiesce: all pixels back, then let trailing loads finish
    task automatic drain();
        int waited;
        start  <= 1'b0;
        waited = 0;
        while (frame_model.expected_pixels.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(int c, int s, int cx, int cy, int w, int h);
        write_reg(REG_COS, c);
        write_reg(REG_SIN, s);
        write_reg(REG_CX, cx);
        write_reg(REG_CY, cy);
        write_reg(REG_W, w);
        write_reg(REG_H, h);
    endtask

    function automatic t_in_word random_word(logic op);
        t_in_word w;
        w.operation = op;
        w.red   = 8'($urandom_range(0, 255));
        w.green = 8'($urandom_range(0, 255));
        w.blue  = 8'($urandom_range(0, 255));
        // black pixels leave holes worth filling
        if ($urandom_range(0, 7) == 0) begin
            w.red = '0; w.green = '0; w.blue = '0;
        end
        return w;
    endfunction

    // one image: n loads then n emits, a few operations flipped as noise
    task automatic run_image(int n, int noise_pct);
        t_in_word w;
        logic op;
        for (int k = 0; k < 2 * n; k++) begin
            op = (k < n) ? OP_LOAD : OP_EMIT;
            if ($urandom_range(0, 99) < noise_pct) op = ~op;
            w = random_word(op);
            send_word(w);
        end
        phases_run++;
    endtask

    initial begin
        t_in_word w;
        int       ang_deg, c, s, iw, ih;
        real      rad;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity 4x3 image, color extremes, black pixels as holes
        configure(16384, 0, 1, 1, 4, 3);
        for (int k = 0; k < 12; k++) begin
            w.operation = OP_LOAD;
            w.red   = (k % 3 == 0) ? 8'hff : 8'h00;
            w.green = (k % 3 == 1) ? 8'hff : 8'h00;
            w.blue  = (k % 3 == 2 || k == 11) ? 8'hff : 8'h00;
            if (k == 5 || k == 6) w = '0;
            if (k == 0) begin
                w.red = 8'hff; w.green = 8'hff; w.blue = 8'hff;
            end
            send_word(w);
        end
        for (int k = 0; k < 12; k++) begin
            w = '1;
            w.operation = OP_EMIT;
            send_word(w);
        end
        phases_run++;
        drain();

        // register extremes: clamped sizes, far centers, out-of-range angles
        configure(16384, 0, 0, 0, 0, 1023);
        run_image(20, 0);
        drain();
        configure(-16384, 0, 511, 511, 1023, 0);
        run_image(20, 0);
        drain();
        configure(0, 16384, 3, 3, 6, 6);
        run_image(36, 0);
        drain();
        configure(0, -16384, 2, 2, 5, 5);
        run_image(25, 0);
        drain();
        configure(-32768, 32767, 4, 4, 8, 8);
        run_image(64, 5);
        drain();
        configure(32767, -32768, 511, 0, 3, 7);
        run_image(21, 5);
        drain();

        // random rotations of small images, odd partial images now and then
        while (frame_model.words_taken < 1250) begin
            ang_deg = $urandom_range(0, 359);
            rad = ang_deg * 3.1415926535 / 180.0;
            c = $rtoi($cos(rad) * 16384.0);
            s = $rtoi($sin(rad) * 16384.0);
            iw = $urandom_range(1, 14);
            ih = $urandom_range(1, 14);
            configure(c, s, $urandom_range(0, iw), $urandom_range(0, ih), iw, ih);
            if ($urandom_range(0, 9) == 0)
                run_image($urandom_range(1, iw * ih + 5), 20);
            else
                run_image(iw * ih, 3);
            drain();
        end

        drain();
        if (frame_model.expected_pixels.size() != 0) begin
            $error("%0d pixels never returned", frame_model.expected_pixels.size());
            frame_model.mismatches++;
        end

        $display("covered %0d images, %0d words in, %0d pixels checked",
                 phases_run, frame_model.words_taken, frame_model.pixels_seen);
        if (frame_model.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== gray_rotate_hole_fill.f =====
rtl/grhf_pkg.sv
rtl/grhf_front.sv
rtl/grhf_back.sv
rtl/gray_rotate_hole_fill.sv
verif/testbench.sv
